/* hw/rtl/tvs_pkg.sv */
// Shared types, codes and constants of the timed valve open/close sequencer.
package tvs_pkg;

    // Width of the configuration data and of the timer targets
    localparam int CFG_W = 16;

    // Default width of the timer counters
    localparam int TIMER_BITS_DEFAULT = 16;

    // Timeout used when an alarm time register holds zero
    localparam logic [CFG_W-1:0] ALARM_TIME_DEFAULT = 16'd500;

    // Command carried by a request
    typedef enum logic [2:0] {
        OP_TICK      = 3'd0,
        OP_CLOSE     = 3'd1,
        OP_OPEN      = 3'd2,
        OP_CAL_CLOSE = 3'd3,
        OP_CAL_OPEN  = 3'd4,
        OP_MAN_STOP  = 3'd5,
        OP_EMG_STOP  = 3'd6
    } op_t;

    // Configuration register indexes
    typedef enum logic [2:0] {
        CFG_OPTION_ENABLED   = 3'd0,
        CFG_CLOSE_DELAY      = 3'd1,
        CFG_CLOSE_ALARM_TIME = 3'd2,
        CFG_CLOSE_HOLD_TIME  = 3'd3,
        CFG_OPEN_DELAY       = 3'd4,
        CFG_OPEN_TIME        = 3'd5,
        CFG_OPEN_ALARM_TIME  = 3'd6
    } cfg_idx_t;

    // Setpoint selector codes
    typedef enum logic [2:0] {
        SEL_ZERO     = 3'd0,
        SEL_CLOSE    = 3'd1,
        SEL_OPEN     = 3'd2,
        SEL_RESET    = 3'd3,
        SEL_CAL_ZERO = 3'd4,
        SEL_CAL_MAX  = 3'd5
    } sel_t;

    // Sequencer phases, one-hot
    typedef enum logic [19:0] {
        PH_IDLE       = 20'h00001,
        PH_CLS_START  = 20'h00002,
        PH_CLS_DELAY  = 20'h00004,
        PH_CLS_ARM    = 20'h00008,
        PH_CLS_DRIVE  = 20'h00010,
        PH_HOLD_START = 20'h00020,
        PH_HOLD       = 20'h00040,
        PH_CLS_END    = 20'h00080,
        PH_CLS_DONE   = 20'h00100,
        PH_CAL_CLS    = 20'h00200,
        PH_OPN_START  = 20'h00400,
        PH_OPN_DELAY  = 20'h00800,
        PH_OPN_ARM    = 20'h01000,
        PH_OPN_DRIVE  = 20'h02000,
        PH_OPN_END    = 20'h04000,
        PH_OPN_DONE   = 20'h08000,
        PH_CAL_OPN    = 20'h10000,
        PH_MAN_STOP   = 20'h20000,
        PH_EMG_STOP   = 20'h40000,
        PH_ERR_STOP   = 20'h80000
    } phase_t;

    // Configuration register contents
    typedef struct packed {
        logic             option_enabled;
        logic [CFG_W-1:0] close_delay;
        logic [CFG_W-1:0] close_alarm_time;
        logic [CFG_W-1:0] close_hold_time;
        logic [CFG_W-1:0] open_delay;
        logic [CFG_W-1:0] open_time;
        logic [CFG_W-1:0] open_alarm_time;
    } cfg_t;

    // Timer command: start loads the target and runs, stop wins over start
    typedef struct packed {
        logic             start;
        logic             stop;
        logic [CFG_W-1:0] target;
    } tmr_cmd_t;

    // Sequencer state after the current request
    typedef struct packed {
        logic       open_valve;
        logic       close_valve;
        sel_t       sel;
        logic [4:0] phase;
        logic       close_alarm;
        logic       open_alarm;
    } seq_out_t;

    // Dense phase number reported on the result
    function automatic logic [4:0] phase_index(phase_t ph);
        logic [4:0] idx;
        unique case (ph)
            PH_IDLE:       idx = 5'd0;
            PH_CLS_START:  idx = 5'd1;
            PH_CLS_DELAY:  idx = 5'd2;
            PH_CLS_ARM:    idx = 5'd3;
            PH_CLS_DRIVE:  idx = 5'd4;
            PH_HOLD_START: idx = 5'd5;
            PH_HOLD:       idx = 5'd6;
            PH_CLS_END:    idx = 5'd7;
            PH_CLS_DONE:   idx = 5'd8;
            PH_CAL_CLS:    idx = 5'd9;
            PH_OPN_START:  idx = 5'd10;
            PH_OPN_DELAY:  idx = 5'd11;
            PH_OPN_ARM:    idx = 5'd12;
            PH_OPN_DRIVE:  idx = 5'd13;
            PH_OPN_END:    idx = 5'd14;
            PH_OPN_DONE:   idx = 5'd15;
            PH_CAL_OPN:    idx = 5'd16;
            PH_MAN_STOP:   idx = 5'd17;
            PH_EMG_STOP:   idx = 5'd18;
            PH_ERR_STOP:   idx = 5'd19;
            default:       idx = 5'd0;
        endcase
        return idx;
    endfunction

endpackage

/* hw/rtl/tvs_timer.sv */
// On-delay timer with run bit, target and saturating counter.
module tvs_timer #(
    parameter int TIMER_BITS = tvs_pkg::TIMER_BITS_DEFAULT
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  step,
    input  tvs_pkg::tmr_cmd_t     cmd,
    output logic                  done,
    output logic [TIMER_BITS-1:0] count_next
);

    localparam int CmpW = (TIMER_BITS > tvs_pkg::CFG_W) ? TIMER_BITS : tvs_pkg::CFG_W;

    logic                      run_reg;
    logic                      run_next;
    logic [tvs_pkg::CFG_W-1:0] target_reg;
    logic [tvs_pkg::CFG_W-1:0] target_next;
    logic [TIMER_BITS-1:0]     count_reg;

    // Done is taken from the state at the start of the request.
    assign done = run_reg && (CmpW'(count_reg) >= CmpW'(target_reg));

    // Apply the command, then advance the count against the new target.
    always_comb
    begin
        run_next    = cmd.stop ? 1'b0 : (cmd.start ? 1'b1 : run_reg);
        target_next = cmd.start ? cmd.target : target_reg;
        priority if (!run_next)
        begin
            count_next = '0;
        end
        else if ((CmpW'(count_reg) < CmpW'(target_next)) && (count_reg != '1))
        begin
            count_next = count_reg + 1'b1;
        end
        else
        begin
            count_next = count_reg;
        end
    end

    // Timer state advances once per request.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg    <= 1'b0;
            target_reg <= '0;
            count_reg  <= '0;
        end
        else if (step)
        begin
            run_reg    <= run_next;
            target_reg <= target_next;
            count_reg  <= count_next;
        end
    end

endmodule

/* hw/rtl/tvs_sequencer.sv */
// Phase sequencer: command decode, valve drives, setpoint, alarms and timer commands.
module tvs_sequencer (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  logic [2:0]        operation,
    input  logic              close_limit,
    input  logic              machine_reset,
    input  logic              time_limit_enable,
    input  tvs_pkg::cfg_t     cfg,
    input  logic              delay_done,
    input  logic              limit_done,
    output tvs_pkg::tmr_cmd_t delay_cmd,
    output tvs_pkg::tmr_cmd_t limit_cmd,
    output tvs_pkg::seq_out_t seq_out
);

    tvs_pkg::phase_t phase_reg;
    tvs_pkg::phase_t phase_next;
    tvs_pkg::phase_t phase_cmd;
    logic            open_valve_reg;
    logic            open_valve_next;
    logic            close_valve_reg;
    logic            close_valve_next;
    tvs_pkg::sel_t   sel_reg;
    tvs_pkg::sel_t   sel_next;
    logic [1:0]      alarm_reg;
    logic [1:0]      alarm_next;
    logic [tvs_pkg::CFG_W-1:0] close_alarm_time;
    logic [tvs_pkg::CFG_W-1:0] open_alarm_time;

    // A zero alarm time falls back to the default timeout.
    assign close_alarm_time = (cfg.close_alarm_time != '0) ? cfg.close_alarm_time
                                                           : tvs_pkg::ALARM_TIME_DEFAULT;
    assign open_alarm_time  = (cfg.open_alarm_time != '0) ? cfg.open_alarm_time
                                                          : tvs_pkg::ALARM_TIME_DEFAULT;

    // A command overrides the phase before the phase is processed.
    always_comb
    begin
        unique case (tvs_pkg::op_t'(operation))
            tvs_pkg::OP_CLOSE:     phase_cmd = tvs_pkg::PH_CLS_START;
            tvs_pkg::OP_OPEN:      phase_cmd = tvs_pkg::PH_OPN_START;
            tvs_pkg::OP_CAL_CLOSE: phase_cmd = tvs_pkg::PH_CAL_CLS;
            tvs_pkg::OP_CAL_OPEN:  phase_cmd = tvs_pkg::PH_CAL_OPN;
            tvs_pkg::OP_MAN_STOP:  phase_cmd = tvs_pkg::PH_MAN_STOP;
            tvs_pkg::OP_EMG_STOP:  phase_cmd = tvs_pkg::PH_EMG_STOP;
            default:               phase_cmd = phase_reg;
        endcase
    end

    // Phase processing and timeout supervision for one request.
    always_comb
    begin
        phase_next       = phase_cmd;
        open_valve_next  = open_valve_reg;
        close_valve_next = close_valve_reg;
        sel_next         = sel_reg;
        alarm_next       = alarm_reg;
        delay_cmd        = '0;
        limit_cmd        = '0;

        unique case (phase_cmd)
            tvs_pkg::PH_IDLE:
            begin
                open_valve_next  = 1'b0;
                close_valve_next = 1'b0;
                delay_cmd.stop   = 1'b1;
                limit_cmd.stop   = 1'b1;
            end
            tvs_pkg::PH_CLS_START:
            begin
                if (cfg.option_enabled)
                begin
                    delay_cmd.start  = 1'b1;
                    delay_cmd.target = cfg.close_delay;
                    phase_next       = tvs_pkg::PH_CLS_DELAY;
                end
                else
                begin
                    phase_next = tvs_pkg::PH_CLS_ARM;
                end
            end
            tvs_pkg::PH_CLS_DELAY:
            begin
                if (delay_done)
                begin
                    delay_cmd.stop = 1'b1;
                    phase_next     = tvs_pkg::PH_CLS_ARM;
                end
            end
            tvs_pkg::PH_CLS_ARM:
            begin
                priority if (cfg.option_enabled)
                begin
                    limit_cmd.start  = 1'b1;
                    limit_cmd.target = close_alarm_time;
                    phase_next       = tvs_pkg::PH_CLS_DRIVE;
                end
                else if (close_limit)
                begin
                    phase_next = tvs_pkg::PH_CLS_END;
                end
                else
                begin
                    alarm_next[0] = 1'b1;
                    phase_next    = tvs_pkg::PH_ERR_STOP;
                end
            end
            tvs_pkg::PH_CLS_DRIVE:
            begin
                open_valve_next  = 1'b0;
                close_valve_next = 1'b1;
                sel_next         = machine_reset ? tvs_pkg::SEL_RESET : tvs_pkg::SEL_CLOSE;
                if (close_limit)
                begin
                    phase_next = tvs_pkg::PH_HOLD_START;
                end
            end
            tvs_pkg::PH_HOLD_START:
            begin
                delay_cmd.start  = 1'b1;
                delay_cmd.target = cfg.close_hold_time;
                phase_next       = tvs_pkg::PH_HOLD;
            end
            tvs_pkg::PH_HOLD:
            begin
                if (delay_done)
                begin
                    delay_cmd.stop = 1'b1;
                    limit_cmd.stop = 1'b1;
                    phase_next     = tvs_pkg::PH_CLS_END;
                end
            end
            tvs_pkg::PH_CLS_END:
            begin
                open_valve_next  = 1'b0;
                close_valve_next = 1'b0;
                sel_next         = tvs_pkg::SEL_ZERO;
                delay_cmd.stop   = 1'b1;
                limit_cmd.stop   = 1'b1;
                phase_next       = tvs_pkg::PH_CLS_DONE;
            end
            tvs_pkg::PH_CAL_CLS:
            begin
                open_valve_next  = 1'b0;
                close_valve_next = !close_limit;
                sel_next         = close_limit ? tvs_pkg::SEL_ZERO : tvs_pkg::SEL_CAL_ZERO;
            end
            tvs_pkg::PH_OPN_START:
            begin
                if (cfg.option_enabled && (cfg.open_delay != '0))
                begin
                    delay_cmd.start  = 1'b1;
                    delay_cmd.target = cfg.open_delay;
                    phase_next       = tvs_pkg::PH_OPN_DELAY;
                end
                else
                begin
                    phase_next = tvs_pkg::PH_OPN_ARM;
                end
            end
            tvs_pkg::PH_OPN_DELAY:
            begin
                if (delay_done)
                begin
                    delay_cmd.stop = 1'b1;
                    phase_next     = tvs_pkg::PH_OPN_ARM;
                end
            end
            tvs_pkg::PH_OPN_ARM:
            begin
                if (cfg.option_enabled && (cfg.open_time != '0))
                begin
                    limit_cmd.start  = 1'b1;
                    limit_cmd.target = open_alarm_time;
                    delay_cmd.start  = 1'b1;
                    delay_cmd.target = cfg.open_time;
                    phase_next       = tvs_pkg::PH_OPN_DRIVE;
                end
                else
                begin
                    phase_next = tvs_pkg::PH_OPN_END;
                end
            end
            tvs_pkg::PH_OPN_DRIVE:
            begin
                open_valve_next  = 1'b1;
                close_valve_next = 1'b0;
                sel_next         = machine_reset ? tvs_pkg::SEL_RESET : tvs_pkg::SEL_OPEN;
                if (delay_done)
                begin
                    delay_cmd.stop = 1'b1;
                    limit_cmd.stop = 1'b1;
                    phase_next     = tvs_pkg::PH_OPN_END;
                end
            end
            tvs_pkg::PH_OPN_END:
            begin
                open_valve_next  = 1'b0;
                close_valve_next = 1'b0;
                sel_next         = tvs_pkg::SEL_ZERO;
                delay_cmd.stop   = 1'b1;
                limit_cmd.stop   = 1'b1;
                phase_next       = tvs_pkg::PH_OPN_DONE;
            end
            tvs_pkg::PH_CAL_OPN:
            begin
                open_valve_next  = 1'b1;
                close_valve_next = 1'b0;
                sel_next         = tvs_pkg::SEL_CAL_MAX;
            end
            tvs_pkg::PH_MAN_STOP,
            tvs_pkg::PH_EMG_STOP:
            begin
                open_valve_next  = 1'b0;
                close_valve_next = 1'b0;
                sel_next         = tvs_pkg::SEL_ZERO;
                delay_cmd.stop   = 1'b1;
                limit_cmd.stop   = 1'b1;
                phase_next       = tvs_pkg::PH_IDLE;
            end
            tvs_pkg::PH_ERR_STOP:
            begin
                open_valve_next  = 1'b0;
                close_valve_next = 1'b0;
                sel_next         = tvs_pkg::SEL_ZERO;
                delay_cmd.stop   = 1'b1;
                limit_cmd.stop   = 1'b1;
            end
            default:
            begin
            end
        endcase

        // A timeout raises the alarm of the running movement and stops the sequence.
        if (limit_done && time_limit_enable)
        begin
            if ((phase_next == tvs_pkg::PH_CLS_DRIVE) || (phase_next == tvs_pkg::PH_HOLD_START)
                || (phase_next == tvs_pkg::PH_HOLD) || (phase_next == tvs_pkg::PH_CLS_END))
            begin
                alarm_next[0] = 1'b1;
            end
            if ((phase_next == tvs_pkg::PH_OPN_DRIVE) || (phase_next == tvs_pkg::PH_OPN_END))
            begin
                alarm_next[1] = 1'b1;
            end
            limit_cmd.stop = 1'b1;
            phase_next     = tvs_pkg::PH_ERR_STOP;
        end
    end

    // Sequencer state advances once per request.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= tvs_pkg::PH_EMG_STOP;
            open_valve_reg  <= 1'b0;
            close_valve_reg <= 1'b0;
            sel_reg         <= tvs_pkg::SEL_ZERO;
            alarm_reg       <= 2'b00;
        end
        else if (step)
        begin
            phase_reg       <= phase_next;
            open_valve_reg  <= open_valve_next;
            close_valve_reg <= close_valve_next;
            sel_reg         <= sel_next;
            alarm_reg       <= alarm_next;
        end
    end

    // State after this request, for the result register.
    always_comb
    begin
        seq_out.open_valve  = open_valve_next;
        seq_out.close_valve = close_valve_next;
        seq_out.sel         = sel_next;
        seq_out.phase       = tvs_pkg::phase_index(phase_next);
        seq_out.close_alarm = alarm_next[0];
        seq_out.open_alarm  = alarm_next[1];
    end

endmodule

/* hw/rtl/timed_valve_open_close_sequencer.sv */
// Top level of the timed valve open/close sequencer.
// Every request is one control tick and yields exactly one result. A request is
// captured in an input register, processed by the phase sequencer and the delay
// and timeout timers, and its result lands in an output register. The block takes
// a new request every clock as long as results are taken. The phase update and the
// two counter updates set that rate of one request per cycle. There is no start-up
// pass after reset; configuration writes take effect on the next request.
module timed_valve_open_close_sequencer #(
    parameter int TIMER_BITS = tvs_pkg::TIMER_BITS_DEFAULT
) (
    input  logic                      clk,
    input  logic                      rst_n,
    // Configuration write port
    input  logic                      cfg_we,
    input  logic [2:0]                cfg_index,
    input  logic [tvs_pkg::CFG_W-1:0] cfg_data,
    // Request channel
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [2:0]                operation,
    input  logic                      close_limit,
    input  logic                      machine_reset,
    input  logic                      time_limit_enable,
    // Result channel
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic                      open_valve,
    output logic                      close_valve,
    output logic [2:0]                setpoint_select,
    output logic [4:0]                phase,
    output logic [15:0]               delay_elapsed,
    output logic [15:0]               limit_elapsed,
    output logic                      close_alarm,
    output logic                      open_alarm
);

    tvs_pkg::cfg_t     cfg_reg;
    logic              req_valid_reg;
    logic [2:0]        req_operation_reg;
    logic              req_close_limit_reg;
    logic              req_machine_reset_reg;
    logic              req_time_limit_enable_reg;
    logic              step;
    tvs_pkg::tmr_cmd_t delay_cmd;
    tvs_pkg::tmr_cmd_t limit_cmd;
    logic              delay_done;
    logic              limit_done;
    logic [TIMER_BITS-1:0] delay_count_next;
    logic [TIMER_BITS-1:0] limit_count_next;
    tvs_pkg::seq_out_t seq_out;
    logic              out_valid_reg;
    logic              out_open_valve_reg;
    logic              out_close_valve_reg;
    logic [2:0]        out_sel_reg;
    logic [4:0]        out_phase_reg;
    logic [15:0]       out_delay_reg;
    logic [15:0]       out_limit_reg;
    logic              out_close_alarm_reg;
    logic              out_open_alarm_reg;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.option_enabled   <= 1'b0;
            cfg_reg.close_delay      <= '0;
            cfg_reg.close_alarm_time <= tvs_pkg::ALARM_TIME_DEFAULT;
            cfg_reg.close_hold_time  <= '0;
            cfg_reg.open_delay       <= '0;
            cfg_reg.open_time        <= '0;
            cfg_reg.open_alarm_time  <= tvs_pkg::ALARM_TIME_DEFAULT;
        end
        else if (cfg_we)
        begin
            unique case (tvs_pkg::cfg_idx_t'(cfg_index))
                tvs_pkg::CFG_OPTION_ENABLED:   cfg_reg.option_enabled   <= cfg_data[0];
                tvs_pkg::CFG_CLOSE_DELAY:      cfg_reg.close_delay      <= cfg_data;
                tvs_pkg::CFG_CLOSE_ALARM_TIME: cfg_reg.close_alarm_time <= cfg_data;
                tvs_pkg::CFG_CLOSE_HOLD_TIME:  cfg_reg.close_hold_time  <= cfg_data;
                tvs_pkg::CFG_OPEN_DELAY:       cfg_reg.open_delay       <= cfg_data;
                tvs_pkg::CFG_OPEN_TIME:        cfg_reg.open_time        <= cfg_data;
                tvs_pkg::CFG_OPEN_ALARM_TIME:  cfg_reg.open_alarm_time  <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    // The held request is processed when the result register is free or draining.
    assign step     = req_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !req_valid_reg || step;

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            req_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            req_operation_reg         <= operation;
            req_close_limit_reg       <= close_limit;
            req_machine_reset_reg     <= machine_reset;
            req_time_limit_enable_reg <= time_limit_enable;
        end
    end

    // Phase sequencer.
    tvs_sequencer u_sequencer (
        .clk               (clk),
        .rst_n             (rst_n),
        .step              (step),
        .operation         (req_operation_reg),
        .close_limit       (req_close_limit_reg),
        .machine_reset     (req_machine_reset_reg),
        .time_limit_enable (req_time_limit_enable_reg),
        .cfg               (cfg_reg),
        .delay_done        (delay_done),
        .limit_done        (limit_done),
        .delay_cmd         (delay_cmd),
        .limit_cmd         (limit_cmd),
        .seq_out           (seq_out)
    );

    // Delay and hold timer.
    tvs_timer #(
        .TIMER_BITS (TIMER_BITS)
    ) u_delay_timer (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (step),
        .cmd        (delay_cmd),
        .done       (delay_done),
        .count_next (delay_count_next)
    );

    // Timeout timer.
    tvs_timer #(
        .TIMER_BITS (TIMER_BITS)
    ) u_limit_timer (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (step),
        .cmd        (limit_cmd),
        .done       (limit_done),
        .count_next (limit_count_next)
    );

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (step)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            out_open_valve_reg  <= seq_out.open_valve;
            out_close_valve_reg <= seq_out.close_valve;
            out_sel_reg         <= seq_out.sel;
            out_phase_reg       <= seq_out.phase;
            out_delay_reg       <= 16'(delay_count_next);
            out_limit_reg       <= 16'(limit_count_next);
            out_close_alarm_reg <= seq_out.close_alarm;
            out_open_alarm_reg  <= seq_out.open_alarm;
        end
    end

    assign out_valid       = out_valid_reg;
    assign open_valve      = out_open_valve_reg;
    assign close_valve     = out_close_valve_reg;
    assign setpoint_select = out_sel_reg;
    assign phase           = out_phase_reg;
    assign delay_elapsed   = out_delay_reg;
    assign limit_elapsed   = out_limit_reg;
    assign close_alarm     = out_close_alarm_reg;
    assign open_alarm      = out_open_alarm_reg;

    // A waiting result must not be overwritten.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_ready |-> !step)
        else $error("result register overwritten while stalled");

    // Every processed request leaves a result.
    a_step_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        step |=> out_valid_reg)
        else $error("processed request produced no result");

    // The two valves are never driven together.
    a_valves_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(out_open_valve_reg && out_close_valve_reg))
        else $error("open and close valve driven together");

    // Alarms are sticky from one result to the next.
    a_alarm_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && step && out_close_alarm_reg && out_open_alarm_reg
        |=> out_close_alarm_reg && out_open_alarm_reg)
        else $error("alarm cleared without reset");

endmodule

/* verif/timed_valve_open_close_sequencer_tb.sv */
// Self-checking testbench for the timed valve open/close sequencer.
module timed_valve_open_close_sequencer_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int          LIMIT_CYCLES = 200000;
    localparam int          HOLD_CYCLES  = 60;
    localparam int          SETTLE_TICKS = 4;
    localparam int          MAX_PRINTS   = 40;
    localparam logic [2:0]  OP_UNUSED    = 3'd7;

    // Dense phase numbers as they appear on the phase output
    typedef enum logic [4:0] {
        SQ_IDLE, SQ_CLS_START, SQ_CLS_DELAY, SQ_CLS_ARM, SQ_CLS_DRIVE,
        SQ_HOLD_START, SQ_HOLD, SQ_CLS_END, SQ_CLS_DONE, SQ_CAL_CLS,
        SQ_OPN_START, SQ_OPN_DELAY, SQ_OPN_ARM, SQ_OPN_DRIVE, SQ_OPN_END,
        SQ_OPN_DONE, SQ_CAL_OPN, SQ_MAN_STOP, SQ_EMG_STOP, SQ_ERR_STOP
    } step_t;

    // One result of the sequencer
    typedef struct {
        logic        open_valve;
        logic        close_valve;
        logic [2:0]  setpoint;
        logic [4:0]  phase;
        logic [15:0] delay_elapsed;
        logic [15:0] limit_elapsed;
        logic        close_alarm;
        logic        open_alarm;
    } tick_result_t;

    // Predicts the sequencer tick by tick and checks its results in order.
    class valve_tick_checker;
        logic          opt_en;
        logic [15:0]   cls_delay, cls_alarm, cls_hold;
        logic [15:0]   opn_delay, opn_time, opn_alarm;
        step_t         step;
        logic [15:0]   dly_cnt, dly_tgt, lim_cnt, lim_tgt;
        logic          dly_run, lim_run;
        logic [1:0]    alarms;
        logic          v_open, v_close;
        tvs_pkg::sel_t setpt;
        tick_result_t  expected_ticks[$];
        int            errors;
        int            n_results;

        function new();
            opt_en    = 1'b0;
            cls_delay = '0;
            cls_alarm = tvs_pkg::ALARM_TIME_DEFAULT;
            cls_hold  = '0;
            opn_delay = '0;
            opn_time  = '0;
            opn_alarm = tvs_pkg::ALARM_TIME_DEFAULT;
            step      = SQ_EMG_STOP;
            dly_cnt   = '0;
            dly_tgt   = '0;
            dly_run   = 1'b0;
            lim_cnt   = '0;
            lim_tgt   = '0;
            lim_run   = 1'b0;
            alarms    = '0;
            v_open    = 1'b0;
            v_close   = 1'b0;
            setpt     = tvs_pkg::SEL_ZERO;
            errors    = 0;
            n_results = 0;
        endfunction

        function void set_reg(tvs_pkg::cfg_idx_t idx, logic [15:0] val);
            case (idx)
                tvs_pkg::CFG_OPTION_ENABLED:   opt_en = val[0];
                tvs_pkg::CFG_CLOSE_DELAY:      cls_delay = val;
                tvs_pkg::CFG_CLOSE_ALARM_TIME: cls_alarm = val;
                tvs_pkg::CFG_CLOSE_HOLD_TIME:  cls_hold = val;
                tvs_pkg::CFG_OPEN_DELAY:       opn_delay = val;
                tvs_pkg::CFG_OPEN_TIME:        opn_time = val;
                tvs_pkg::CFG_OPEN_ALARM_TIME:  opn_alarm = val;
                default: ;
            endcase
        endfunction

        function int pending();
            return expected_ticks.size();
        endfunction

        function void valves_off();
            v_open  = 1'b0;
            v_close = 1'b0;
            setpt   = tvs_pkg::SEL_ZERO;
            dly_run = 1'b0;
            lim_run = 1'b0;
        endfunction

        // On-delay timer: counts while running up to the target, clears when stopped
        function logic [15:0] timer_step(logic run, logic [15:0] cnt, logic [15:0] tgt);
            if (!run)
                return '0;
            if (cnt < tgt && cnt != 16'hFFFF)
                return cnt + 16'd1;
            return cnt;
        endfunction

        // Works out the result of one accepted request.
        function void note_request(logic [2:0] op, logic lim, logic mreset, logic tle);
            logic         dly_done, lim_done;
            logic [15:0]  cls_to, opn_to;
            tick_result_t r;
            cls_to   = (cls_alarm != 0) ? cls_alarm : tvs_pkg::ALARM_TIME_DEFAULT;
            opn_to   = (opn_alarm != 0) ? opn_alarm : tvs_pkg::ALARM_TIME_DEFAULT;
            dly_done = dly_run && (dly_cnt >= dly_tgt);
            lim_done = lim_run && (lim_cnt >= lim_tgt);

            // A command overrides the phase at once
            case (op)
                tvs_pkg::OP_CLOSE:     step = SQ_CLS_START;
                tvs_pkg::OP_OPEN:      step = SQ_OPN_START;
                tvs_pkg::OP_CAL_CLOSE: step = SQ_CAL_CLS;
                tvs_pkg::OP_CAL_OPEN:  step = SQ_CAL_OPN;
                tvs_pkg::OP_MAN_STOP:  step = SQ_MAN_STOP;
                tvs_pkg::OP_EMG_STOP:  step = SQ_EMG_STOP;
                default: ;
            endcase

            case (step)
                SQ_IDLE:
                begin
                    v_open  = 1'b0;
                    v_close = 1'b0;
                    dly_run = 1'b0;
                    lim_run = 1'b0;
                end
                SQ_CLS_START:
                begin
                    if (opt_en) begin
                        dly_run = 1'b1;
                        dly_tgt = cls_delay;
                        step    = SQ_CLS_DELAY;
                    end else begin
                        step = SQ_CLS_ARM;
                    end
                end
                SQ_CLS_DELAY:
                begin
                    if (dly_done) begin
                        dly_run = 1'b0;
                        step    = SQ_CLS_ARM;
                    end
                end
                SQ_CLS_ARM:
                begin
                    if (opt_en) begin
                        lim_run = 1'b1;
                        lim_tgt = cls_to;
                        step    = SQ_CLS_DRIVE;
                    end else if (lim) begin
                        step = SQ_CLS_END;
                    end else begin
                        alarms[0] = 1'b1;
                        step      = SQ_ERR_STOP;
                    end
                end
                SQ_CLS_DRIVE:
                begin
                    v_open  = 1'b0;
                    v_close = 1'b1;
                    if (mreset)
                        setpt = tvs_pkg::SEL_RESET;
                    else
                        setpt = tvs_pkg::SEL_CLOSE;
                    if (lim)
                        step = SQ_HOLD_START;
                end
                SQ_HOLD_START:
                begin
                    dly_run = 1'b1;
                    dly_tgt = cls_hold;
                    step    = SQ_HOLD;
                end
                SQ_HOLD:
                begin
                    if (dly_done) begin
                        dly_run = 1'b0;
                        lim_run = 1'b0;
                        step    = SQ_CLS_END;
                    end
                end
                SQ_CLS_END:
                begin
                    valves_off();
                    step = SQ_CLS_DONE;
                end
                SQ_CAL_CLS:
                begin
                    v_open = 1'b0;
                    if (!lim) begin
                        v_close = 1'b1;
                        setpt   = tvs_pkg::SEL_CAL_ZERO;
                    end else begin
                        v_close = 1'b0;
                        setpt   = tvs_pkg::SEL_ZERO;
                    end
                end
                SQ_OPN_START:
                begin
                    if (opt_en && opn_delay != 0) begin
                        dly_run = 1'b1;
                        dly_tgt = opn_delay;
                        step    = SQ_OPN_DELAY;
                    end else begin
                        step = SQ_OPN_ARM;
                    end
                end
                SQ_OPN_DELAY:
                begin
                    if (dly_done) begin
                        dly_run = 1'b0;
                        step    = SQ_OPN_ARM;
                    end
                end
                SQ_OPN_ARM:
                begin
                    if (opt_en && opn_time != 0) begin
                        lim_run = 1'b1;
                        lim_tgt = opn_to;
                        dly_run = 1'b1;
                        dly_tgt = opn_time;
                        step    = SQ_OPN_DRIVE;
                    end else begin
                        step = SQ_OPN_END;
                    end
                end
                SQ_OPN_DRIVE:
                begin
                    v_open  = 1'b1;
                    v_close = 1'b0;
                    if (mreset)
                        setpt = tvs_pkg::SEL_RESET;
                    else
                        setpt = tvs_pkg::SEL_OPEN;
                    if (dly_done) begin
                        dly_run = 1'b0;
                        lim_run = 1'b0;
                        step    = SQ_OPN_END;
                    end
                end
                SQ_OPN_END:
                begin
                    valves_off();
                    step = SQ_OPN_DONE;
                end
                SQ_CAL_OPN:
                begin
                    v_open  = 1'b1;
                    v_close = 1'b0;
                    setpt   = tvs_pkg::SEL_CAL_MAX;
                end
                SQ_MAN_STOP, SQ_EMG_STOP:
                begin
                    valves_off();
                    step = SQ_IDLE;
                end
                SQ_ERR_STOP:
                begin
                    valves_off();
                end
                default: ;
            endcase

            // Timeout supervision raises the alarm of the motion under way
            if (lim_done && tle) begin
                if (step >= SQ_CLS_DRIVE && step <= SQ_CLS_END)
                    alarms[0] = 1'b1;
                if (step >= SQ_OPN_DRIVE && step <= SQ_OPN_END)
                    alarms[1] = 1'b1;
                lim_run = 1'b0;
                step    = SQ_ERR_STOP;
            end

            dly_cnt = timer_step(dly_run, dly_cnt, dly_tgt);
            lim_cnt = timer_step(lim_run, lim_cnt, lim_tgt);

            r.open_valve    = v_open;
            r.close_valve   = v_close;
            r.setpoint      = setpt;
            r.phase         = step;
            r.delay_elapsed = dly_cnt;
            r.limit_elapsed = lim_cnt;
            r.close_alarm   = alarms[0];
            r.open_alarm    = alarms[1];
            expected_ticks.push_back(r);
        endfunction

        task report(string what);
            errors++;
            if (errors <= MAX_PRINTS)
                $display("MISMATCH at %0t ns: %s", $time, what);
        endtask

        task compare_field(string name, logic [15:0] got, logic [15:0] want);
            if (got !== want)
                report($sformatf("result %0d %s: got %0h, expected %0h",
                                 n_results, name, got, want));
        endtask

        // Compares one accepted result with the oldest prediction.
        task check_result(tick_result_t got);
            tick_result_t want;
            if (expected_ticks.size() == 0) begin
                report("result arrived with no request outstanding");
                return;
            end
            want = expected_ticks.pop_front();
            compare_field("open_valve", got.open_valve, want.open_valve);
            compare_field("close_valve", got.close_valve, want.close_valve);
            compare_field("setpoint_select", got.setpoint, want.setpoint);
            compare_field("phase", got.phase, want.phase);
            compare_field("delay_elapsed", got.delay_elapsed, want.delay_elapsed);
            compare_field("limit_elapsed", got.limit_elapsed, want.limit_elapsed);
            compare_field("close_alarm", got.close_alarm, want.close_alarm);
            compare_field("open_alarm", got.open_alarm, want.open_alarm);
            n_results++;
        endtask
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [15:0] cfg_data = '0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [2:0]  operation = '0;
    logic        close_limit = 1'b0;
    logic        machine_reset = 1'b0;
    logic        time_limit_enable = 1'b0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic        open_valve;
    logic        close_valve;
    logic [2:0]  setpoint_select;
    logic [4:0]  phase;
    logic [15:0] delay_elapsed;
    logic [15:0] limit_elapsed;
    logic        close_alarm;
    logic        open_alarm;

    // Set by the stimulus to switch idling off, or to ask for one long receiver stall
    logic steady = 1'b0;
    logic hold_off_req = 1'b0;

    valve_tick_checker seq_check = new();

    timed_valve_open_close_sequencer u_top (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_we            (cfg_we),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .operation         (operation),
        .close_limit       (close_limit),
        .machine_reset     (machine_reset),
        .time_limit_enable (time_limit_enable),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .open_valve        (open_valve),
        .close_valve       (close_valve),
        .setpoint_select   (setpoint_select),
        .phase             (phase),
        .delay_elapsed     (delay_elapsed),
        .limit_elapsed     (limit_elapsed),
        .close_alarm       (close_alarm),
        .open_alarm        (open_alarm)
    );

    // Clock
    initial
    begin
        forever #5 clk = ~clk;
    end

    // Watchdog against a hung handshake
    initial
    begin
        repeat (LIMIT_CYCLES) @(posedge clk);
        $display("timed_valve_open_close_sequencer_tb failed");
        $finish;
    end

    // Receiver: random stalls, a stall-free stretch and one long hold-off
    initial
    begin : receiver
        int hold_left;
        hold_left = 0;
        forever begin
            @(posedge clk);
            if (hold_off_req && hold_left == 0) begin
                hold_off_req = 1'b0;
                hold_left    = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_ready <= 1'b0;
            end else if (steady) begin
                out_ready <= 1'b1;
            end else begin
                out_ready <= ($urandom_range(99) >= 28);
            end
        end
    end

    // Monitor: record accepted requests and check accepted results
    always @(posedge clk)
    begin : monitor
        tick_result_t got;
        if (rst_n) begin
            if (in_valid && in_ready)
                seq_check.note_request(operation, close_limit, machine_reset,
                                       time_limit_enable);
            if (out_valid && out_ready) begin
                got.open_valve    = open_valve;
                got.close_valve   = close_valve;
                got.setpoint      = setpoint_select;
                got.phase         = phase;
                got.delay_elapsed = delay_elapsed;
                got.limit_elapsed = limit_elapsed;
                got.close_alarm   = close_alarm;
                got.open_alarm    = open_alarm;
                seq_check.check_result(got);
            end
        end
    end

    // Offers one request and returns at the edge that accepts it.
    task automatic send_tick(logic [2:0] op, logic lim, logic mreset, logic tle);
        if (!steady) begin
            while ($urandom_range(99) < 28) begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
        end
        in_valid          <= 1'b1;
        operation         <= op;
        close_limit       <= lim;
        machine_reset     <= mreset;
        time_limit_enable <= tle;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    // Stops offering and waits until every outstanding result is in.
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (seq_check.pending() != 0) @(posedge clk);
        repeat (SETTLE_TICKS) @(posedge clk);
    endtask

    // Writes all seven registers, one per clock.
    task automatic load_settings(logic opt, logic [15:0] cd, logic [15:0] cat,
                                 logic [15:0] ch, logic [15:0] od, logic [15:0] ot,
                                 logic [15:0] oat);
        tvs_pkg::cfg_idx_t regs[7];
        logic [15:0]       vals[7];
        regs = '{tvs_pkg::CFG_OPTION_ENABLED, tvs_pkg::CFG_CLOSE_DELAY,
                 tvs_pkg::CFG_CLOSE_ALARM_TIME, tvs_pkg::CFG_CLOSE_HOLD_TIME,
                 tvs_pkg::CFG_OPEN_DELAY, tvs_pkg::CFG_OPEN_TIME,
                 tvs_pkg::CFG_OPEN_ALARM_TIME};
        vals = '{{15'd0, opt}, cd, cat, ch, od, ot, oat};
        for (int i = 0; i < 7; i++) begin
            cfg_we    <= 1'b1;
            cfg_index <= regs[i];
            cfg_data  <= vals[i];
            seq_check.set_reg(regs[i], vals[i]);
            @(posedge clk);
        end
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // Small random timings so that delays, holds and timeouts all complete
    task automatic load_small_settings();
        load_settings(1'b1, $urandom_range(4), $urandom_range(1, 25), $urandom_range(4),
                      $urandom_range(4), $urandom_range(8), $urandom_range(1, 20));
    endtask

    // Supervision is on for most requests
    function automatic logic tle_pick();
        return ($urandom_range(9) != 0);
    endfunction

    // Random mix of motion runs, calibration runs, noise and interrupted runs.
    task automatic run_mix(int count);
        int         sent;
        int         len;
        int         k;
        int         pick;
        logic       mr;
        logic [2:0] cmd;
        sent = 0;
        while (sent < count) begin
            pick = $urandom_range(99);
            mr   = $urandom_range(1);
            if (pick < 60) begin
                // Close or open run; the limit switch closes at a random tick
                cmd = $urandom_range(1) ? tvs_pkg::OP_CLOSE : tvs_pkg::OP_OPEN;
                len = $urandom_range(3, 24);
                k   = $urandom_range(len + 4);
                send_tick(cmd, 1'b0, mr, tle_pick());
                for (int i = 0; i < len; i++)
                    send_tick(tvs_pkg::OP_TICK, (i >= k), mr, tle_pick());
                sent += len + 1;
            end else if (pick < 75) begin
                // Calibration run ended by a manual stop
                cmd = $urandom_range(1) ? tvs_pkg::OP_CAL_CLOSE : tvs_pkg::OP_CAL_OPEN;
                len = $urandom_range(1, 6);
                send_tick(cmd, $urandom_range(1), mr, tle_pick());
                for (int i = 0; i < len; i++)
                    send_tick(tvs_pkg::OP_TICK, $urandom_range(1), mr, tle_pick());
                send_tick(tvs_pkg::OP_MAN_STOP, $urandom_range(1), mr, tle_pick());
                sent += len + 2;
            end else if (pick < 90) begin
                // Noise, the unused operation code included
                len = $urandom_range(1, 4);
                for (int i = 0; i < len; i++)
                    send_tick($urandom_range(7), $urandom_range(1), $urandom_range(1),
                              $urandom_range(1));
                sent += len;
            end else begin
                // Run cut short by another command
                cmd = $urandom_range(1) ? tvs_pkg::OP_CLOSE : tvs_pkg::OP_OPEN;
                len = $urandom_range(0, 5);
                send_tick(cmd, 1'b0, mr, tle_pick());
                for (int i = 0; i < len; i++)
                    send_tick(tvs_pkg::OP_TICK, $urandom_range(1), mr, tle_pick());
                send_tick($urandom_range(tvs_pkg::OP_CLOSE, tvs_pkg::OP_EMG_STOP),
                          $urandom_range(1), mr, tle_pick());
                sent += len + 2;
                len = $urandom_range(0, 4);
                for (int i = 0; i < len; i++)
                    send_tick(tvs_pkg::OP_TICK, $urandom_range(1), mr, tle_pick());
                sent += len;
            end
        end
    endtask

    // Stimulus and final verdict
    initial
    begin : stimulus
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed requests with the reset settings, so the timed option is off
        send_tick(tvs_pkg::OP_TICK, 1'b0, 1'b0, 1'b0);
        send_tick(OP_UNUSED, 1'b1, 1'b1, 1'b1);
        send_tick(tvs_pkg::OP_CAL_CLOSE, 1'b0, 1'b1, 1'b0);
        send_tick(tvs_pkg::OP_TICK, 1'b1, 1'b0, 1'b1);
        send_tick(tvs_pkg::OP_CAL_OPEN, 1'b0, 1'b0, 1'b0);
        send_tick(tvs_pkg::OP_TICK, 1'b0, 1'b0, 1'b0);
        send_tick(tvs_pkg::OP_MAN_STOP, 1'b0, 1'b0, 1'b0);
        // Close with the switch made: straight to close end
        send_tick(tvs_pkg::OP_CLOSE, 1'b1, 1'b0, 1'b1);
        send_tick(tvs_pkg::OP_TICK, 1'b1, 1'b0, 1'b1);
        send_tick(tvs_pkg::OP_TICK, 1'b1, 1'b0, 1'b1);
        send_tick(tvs_pkg::OP_TICK, 1'b0, 1'b0, 1'b1);
        // Close with the switch open: close alarm and error stop, which persists
        send_tick(tvs_pkg::OP_CLOSE, 1'b0, 1'b0, 1'b1);
        send_tick(tvs_pkg::OP_TICK, 1'b0, 1'b0, 1'b1);
        send_tick(tvs_pkg::OP_TICK, 1'b0, 1'b1, 1'b1);
        // Open without the option skips straight to open end
        send_tick(tvs_pkg::OP_OPEN, 1'b0, 1'b1, 1'b0);
        send_tick(tvs_pkg::OP_TICK, 1'b0, 1'b1, 1'b0);
        send_tick(tvs_pkg::OP_TICK, 1'b0, 1'b1, 1'b0);
        send_tick(tvs_pkg::OP_EMG_STOP, 1'b1, 1'b1, 1'b1);
        send_tick(tvs_pkg::OP_CAL_OPEN, 1'b1, 1'b1, 1'b1);
        send_tick(tvs_pkg::OP_TICK, 1'b1, 1'b1, 1'b1);
        send_tick(tvs_pkg::OP_EMG_STOP, 1'b0, 1'b0, 1'b0);
        drain();

        // Every timing at its maximum
        load_settings(1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        run_mix(60);
        drain();

        // Every timing zero: no delays, no opening, default timeouts
        load_settings(1'b1, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        run_mix(60);
        drain();

        // Option off with random timings, limit switch check only
        load_settings(1'b0, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
        run_mix(60);
        drain();

        load_small_settings();
        run_mix(80);
        drain();

        // No idling on either side
        load_small_settings();
        steady = 1'b1;
        run_mix(80);
        steady = 1'b0;
        drain();

        // Long receiver stall while requests keep coming
        load_small_settings();
        hold_off_req = 1'b1;
        run_mix(90);
        drain();

        load_small_settings();
        run_mix(90);
        drain();

        load_small_settings();
        run_mix(80);
        drain();

        if (seq_check.errors == 0 && seq_check.pending() == 0)
            $display("timed_valve_open_close_sequencer_tb passed");
        else
            $display("timed_valve_open_close_sequencer_tb failed");
        $finish;
    end

endmodule

/* timed_valve_open_close_sequencer.f */
hw/rtl/tvs_pkg.sv
hw/rtl/tvs_timer.sv
hw/rtl/tvs_sequencer.sv
hw/rtl/timed_valve_open_close_sequencer.sv
verif/timed_valve_open_close_sequencer_tb.sv
